FILE: hw/rtl/srrw_pkg.sv
// shared types and constants for the selective repeat receive window
package srrw_pkg;

  localparam int SEQ_W   = 32;
  localparam int LEN_W   = 7;
  localparam int ACT_W   = 2;
  localparam int SLOT_W  = 3;
  localparam int RBYTE_W = 10;
  localparam int RSLOT_W = 4;

  // action codes reported with each acknowledgement
  localparam logic [ACT_W-1:0] ACT_DELIVER = 2'd0;
  localparam logic [ACT_W-1:0] ACT_STORE   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DROP    = 2'd2;

  // incoming packet header word
  typedef struct packed {
    logic [SEQ_W-1:0] seq_number;
    logic [LEN_W-1:0] payload_length;
    logic             final_packet;
  } srrw_in_t;

  // outgoing acknowledgement word
  typedef struct packed {
    logic [SEQ_W-1:0]   ack_number;
    logic [ACT_W-1:0]   action;
    logic [SLOT_W-1:0]  slot_index;
    logic [RBYTE_W-1:0] released_bytes;
    logic [RSLOT_W-1:0] released_slots;
    logic               transfer_done;
  } srrw_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_hdr;
    logic classify;
    logic act;
    logic scan_step;
    logic finish;
    logic emit;
  } srrw_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic deliver;
    logic head_filled;
  } srrw_sts_t;

endpackage

FILE: hw/rtl/srrw_ctrl.sv
// controller state machine for the receive window
module srrw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  srrw_pkg::srrw_sts_t sts,
  output srrw_pkg::srrw_cmd_t cmd
);
  import srrw_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CLASSIFY = 3'd1;
  localparam logic [2:0] S_ACT      = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_FINISH   = 3'd4;
  localparam logic [2:0] S_EMIT     = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // next state and command decode
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_hdr = 1'b1;
          state_nxt    = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        cmd.classify = 1'b1;
        state_nxt    = S_ACT;
      end
      S_ACT: begin
        cmd.act   = 1'b1;
        state_nxt = sts.deliver ? S_SCAN : S_EMIT;
      end
      S_SCAN: begin
        // one buffered slot per cycle while the window head is filled
        if (sts.head_filled) begin
          cmd.scan_step = 1'b1;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hw/rtl/srrw_datapath.sv
// window state, slot bookkeeping and acknowledgement register
module srrw_datapath #(
  parameter int WINDOW_SLOTS = 8,
  parameter int PACKET_BYTES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  srrw_pkg::srrw_cmd_t cmd,
  output srrw_pkg::srrw_sts_t sts,
  input  srrw_pkg::srrw_in_t  in_data,
  output srrw_pkg::srrw_out_t out_data
);
  import srrw_pkg::*;

  localparam int WIN_BYTES = WINDOW_SLOTS * PACKET_BYTES;
  localparam int DW = $clog2(WIN_BYTES + 1);
  localparam int TW = $clog2(WIN_BYTES + PACKET_BYTES + 1);
  localparam int SW = $clog2(WINDOW_SLOTS);
  localparam int NW = $clog2(WINDOW_SLOTS + 1);

  // architectural window state
  logic [SEQ_W-1:0] next_exp_r;
  logic [SEQ_W-1:0] final_num_r;
  logic             slot_filled_r [WINDOW_SLOTS];
  logic [LEN_W-1:0] slot_len_r    [WINDOW_SLOTS];

  // per-packet working registers
  logic [SEQ_W-1:0]  seq_r;
  logic [LEN_W-1:0]  len_r;
  logic [DW-1:0]     diff_r;
  logic              deliver_r;
  logic              in_win_r;
  logic [ACT_W-1:0]  action_r;
  logic [SW-1:0]     slot_r;
  logic [TW-1:0]     total_r;
  logic [NW-1:0]     count_r;
  srrw_out_t         out_r;

  logic [LEN_W-1:0]  len_clamped;
  logic [SEQ_W-1:0]  diff_full;
  logic [DW-1:0]     quot;
  logic [SW-1:0]     slot_calc;
  logic [SEQ_W:0]    next_sum;

  // clamp overlong payloads to one packet
  assign len_clamped = ({{(SEQ_W-LEN_W){1'b0}}, in_data.payload_length} > SEQ_W'(PACKET_BYTES))
                       ? LEN_W'(PACKET_BYTES) : in_data.payload_length;

  assign diff_full = seq_r - next_exp_r;
  assign quot      = diff_r / DW'(PACKET_BYTES);
  assign slot_calc = SW'(quot - DW'(1));
  assign next_sum  = {1'b0, next_exp_r} + (SEQ_W+1)'(total_r);

  assign sts.deliver     = deliver_r;
  assign sts.head_filled = slot_filled_r[0];
  assign out_data        = out_r;

  // window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_exp_r  <= '0;
      final_num_r <= '1;
      for (int k = 0; k < WINDOW_SLOTS; k++) begin
        slot_filled_r[k] <= 1'b0;
      end
    end else begin
      if (cmd.load_hdr && in_data.final_packet) begin
        final_num_r <= in_data.seq_number;
      end
      // record an out-of-order packet in its slot
      if (cmd.act && in_win_r) begin
        slot_filled_r[slot_calc] <= 1'b1;
      end
      // slide the valid bits down by one slot
      if (cmd.scan_step) begin
        for (int k = 0; k < WINDOW_SLOTS - 1; k++) begin
          slot_filled_r[k] <= slot_filled_r[k+1];
        end
        slot_filled_r[WINDOW_SLOTS-1] <= 1'b0;
      end
      // advance the expected number, saturating at the top
      if (cmd.finish) begin
        next_exp_r <= next_sum[SEQ_W] ? '1 : next_sum[SEQ_W-1:0];
      end
    end
  end

  // slot lengths, meaningful only where the slot is filled
  always_ff @(posedge clk) begin
    if (cmd.act && in_win_r) begin
      slot_len_r[slot_calc] <= len_r;
    end
    if (cmd.scan_step) begin
      for (int k = 0; k < WINDOW_SLOTS - 1; k++) begin
        slot_len_r[k] <= slot_len_r[k+1];
      end
    end
  end

  // per-packet work
  always_ff @(posedge clk) begin
    if (cmd.load_hdr) begin
      seq_r <= in_data.seq_number;
      len_r <= len_clamped;
    end
    if (cmd.classify) begin
      deliver_r <= (seq_r == next_exp_r);
      in_win_r  <= (seq_r > next_exp_r) && (diff_full >= SEQ_W'(PACKET_BYTES))
                   && (diff_full <= SEQ_W'(WIN_BYTES));
      diff_r    <= DW'(diff_full);
      total_r   <= TW'(len_r);
      count_r   <= '0;
    end
    if (cmd.act) begin
      if (deliver_r) begin
        action_r <= ACT_DELIVER;
        slot_r   <= '0;
      end else if (in_win_r) begin
        action_r <= ACT_STORE;
        slot_r   <= slot_calc;
      end else begin
        action_r <= ACT_DROP;
        slot_r   <= '0;
      end
    end
    // accumulate the head slot before it shifts out
    if (cmd.scan_step) begin
      total_r <= total_r + TW'(slot_len_r[0]);
      count_r <= count_r + NW'(1);
    end
    if (cmd.emit) begin
      out_r.ack_number     <= seq_r;
      out_r.action         <= action_r;
      out_r.slot_index     <= SLOT_W'(slot_r);
      out_r.released_bytes <= (action_r == ACT_DELIVER) ? RBYTE_W'(total_r) : '0;
      out_r.released_slots <= (action_r == ACT_DELIVER) ? RSLOT_W'(count_r) : '0;
      out_r.transfer_done  <= (next_exp_r >= final_num_r);
    end
  end

endmodule

FILE: hw/rtl/selective_repeat_receive_window_core.sv
// Receive window of a selective repeat receiver with byte sequence numbers.
// Each input word is one packet header and yields exactly one acknowledgement
// word. A packet at the expected number is delivered together with every
// contiguous filled slot above it; a packet one to WINDOW_SLOTS packets ahead
// is recorded in a slot (payload bytes live in an external memory indexed by
// slot_index); anything else is dropped. Sequence numbers do not wrap and the
// expected number saturates at all ones. A dropped or stored packet passes
// the classify, act and emit states on its way to the result register; a
// delivered packet also passes the scan and finish states, which shift window
// valid bits one slot per cycle while the head slot is filled. One header is
// processed at a time; a new header is taken while the last result waits.
module selective_repeat_receive_window_core #(
  parameter int WINDOW_SLOTS = 8,
  parameter int PACKET_BYTES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  srrw_pkg::srrw_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output srrw_pkg::srrw_out_t out_data
);
  import srrw_pkg::*;

  srrw_cmd_t cmd;
  srrw_sts_t sts;

  // sequencing
  srrw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // window state and result
  srrw_datapath #(
    .WINDOW_SLOTS (WINDOW_SLOTS),
    .PACKET_BYTES (PACKET_BYTES)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

FILE: tb/selective_repeat_receive_window_core_test.sv
// testbench for the selective repeat receive window core
`timescale 1ns / 1ps

module selective_repeat_receive_window_core_test;
  import srrw_pkg::*;

  localparam int WINDOW_SLOTS   = 8;
  localparam int PACKET_BYTES   = 64;
  localparam int RANDOM_CHUNKS  = 10;
  localparam int CHUNK_WORDS    = 98;
  localparam int PRESSURE_WORDS = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int STALL_LIMIT    = 3000;
  localparam int DRAIN_CYCLES   = 40;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  srrw_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  srrw_out_t out_data;

  // mirror of the receive window
  logic [SEQ_W-1:0] exp_seq;
  logic [SEQ_W-1:0] last_seq;
  logic             slot_full [WINDOW_SLOTS];
  logic [LEN_W-1:0] slot_len [WINDOW_SLOTS];

  // acknowledgements still owed by the block, oldest first
  srrw_out_t pending_acks [$];

  bit idle_in;
  bit idle_out;
  bit hold_request;
  int error_count;
  int ack_count;
  int deliver_count;
  int store_count;
  int drop_count;
  int done_count;
  int quiet_cycles;

  selective_repeat_receive_window_core #(
    .WINDOW_SLOTS(WINDOW_SLOTS),
    .PACKET_BYTES(PACKET_BYTES)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // window update for one header, returns the acknowledgement it earns
  function automatic srrw_out_t predict_ack(srrw_in_t hdr);
    logic [LEN_W-1:0] len;
    logic [10:0]      total;
    logic [SEQ_W:0]   sum;
    logic [SEQ_W-1:0] ahead;
    int               n;
    int               s;
    srrw_out_t        ack;
    ack = '0;
    ack.ack_number = hdr.seq_number;
    ack.action = ACT_DROP;
    len = (hdr.payload_length > PACKET_BYTES) ? LEN_W'(PACKET_BYTES) : hdr.payload_length;
    if (hdr.final_packet) last_seq = hdr.seq_number;
    if (hdr.seq_number == exp_seq) begin
      // gather the run of filled slots, then slide the window past them
      total = 11'(len);
      n = 0;
      while (n < WINDOW_SLOTS && slot_full[n]) begin
        total += 11'(slot_len[n]);
        n++;
      end
      for (int k = 0; k < WINDOW_SLOTS; k++) begin
        if (k + n < WINDOW_SLOTS) begin
          slot_full[k] = slot_full[k+n];
          slot_len[k] = slot_len[k+n];
        end else begin
          slot_full[k] = 1'b0;
        end
      end
      sum = {1'b0, exp_seq} + 33'(total);
      exp_seq = sum[SEQ_W] ? '1 : sum[SEQ_W-1:0];
      ack.action = ACT_DELIVER;
      ack.released_bytes = RBYTE_W'(total);
      ack.released_slots = RSLOT_W'(n);
    end else if (hdr.seq_number > exp_seq) begin
      // ahead by one to WINDOW_SLOTS packets: buffer it, unaligned rounds down
      ahead = hdr.seq_number - exp_seq;
      if (ahead >= PACKET_BYTES && ahead <= WINDOW_SLOTS * PACKET_BYTES) begin
        s = int'(ahead / PACKET_BYTES) - 1;
        slot_full[s] = 1'b1;
        slot_len[s] = len;
        ack.action = ACT_STORE;
        ack.slot_index = SLOT_W'(s);
      end
    end
    ack.transfer_done = (exp_seq >= last_seq);
    return ack;
  endfunction

  function automatic srrw_in_t make_hdr(logic [SEQ_W-1:0] seq, int len, bit fin);
    srrw_in_t h;
    h.seq_number = seq;
    h.payload_length = LEN_W'(len);
    h.final_packet = fin;
    return h;
  endfunction

  // mostly plausible traffic around the window, with some noise
  function automatic srrw_in_t random_header();
    int               pick;
    int               lpick;
    int               len;
    logic [SEQ_W-1:0] seq;
    pick = $urandom_range(0, 99);
    lpick = $urandom_range(0, 99);
    if (lpick < 55) len = PACKET_BYTES;
    else if (lpick < 65) len = 0;
    else len = $urandom_range(0, 127);
    if (pick < 30) seq = exp_seq;
    else if (pick < 65) seq = exp_seq + PACKET_BYTES * $urandom_range(1, WINDOW_SLOTS);
    else if (pick < 72) seq = exp_seq + $urandom_range(PACKET_BYTES, WINDOW_SLOTS * PACKET_BYTES);
    else if (pick < 78) seq = exp_seq + $urandom_range(1, PACKET_BYTES - 1);
    else if (pick < 84) seq = exp_seq + $urandom_range(WINDOW_SLOTS * PACKET_BYTES + 1, 2000);
    else if (pick < 90) begin
      if (exp_seq == 0) seq = 1;
      else seq = exp_seq - $urandom_range(1, (exp_seq > 1000) ? 1000 : int'(exp_seq));
    end else seq = $urandom;
    return make_hdr(seq, len, $urandom_range(0, 29) == 0);
  endfunction

  // offer one header word, hold it until taken, then predict its ack
  task automatic send_header(srrw_in_t hdr);
    int gap;
    gap = idle_in ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data = hdr;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_acks.push_back(predict_ack(hdr));
    @(negedge clk);
  endtask

  task automatic check_field(string name, logic [SEQ_W-1:0] want, logic [SEQ_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  task automatic test_in_order();
    send_header(make_hdr(exp_seq, PACKET_BYTES, 1'b0));
    // empty payload leaves the expected number in place
    send_header(make_hdr(exp_seq, 0, 1'b0));
    // overlong payload counts as a full packet
    send_header(make_hdr(exp_seq, 127, 1'b0));
    send_header(make_hdr(exp_seq, 1, 1'b0));
  endtask

  task automatic test_window_fill();
    // far edge, near edge, short slot, unaligned number, overwrite
    send_header(make_hdr(exp_seq + WINDOW_SLOTS * PACKET_BYTES, PACKET_BYTES, 1'b0));
    send_header(make_hdr(exp_seq + PACKET_BYTES, PACKET_BYTES, 1'b0));
    send_header(make_hdr(exp_seq + 2 * PACKET_BYTES, 10, 1'b0));
    send_header(make_hdr(exp_seq + 3 * PACKET_BYTES + 5, 65, 1'b0));
    send_header(make_hdr(exp_seq + PACKET_BYTES, 30, 1'b0));
    send_header(make_hdr(exp_seq, PACKET_BYTES, 1'b0));
    // full window then one delivery that releases every slot
    for (int k = 1; k <= WINDOW_SLOTS; k++) begin
      send_header(make_hdr(exp_seq + k * PACKET_BYTES, PACKET_BYTES, 1'b0));
    end
    send_header(make_hdr(exp_seq, PACKET_BYTES, 1'b0));
  endtask

  task automatic test_drops();
    send_header(make_hdr(exp_seq - 1, PACKET_BYTES, 1'b0));
    send_header(make_hdr(exp_seq + PACKET_BYTES - 1, PACKET_BYTES, 1'b0));
    send_header(make_hdr(exp_seq + WINDOW_SLOTS * PACKET_BYTES + 1, PACKET_BYTES, 1'b0));
    send_header(make_hdr('1, 127, 1'b0));
  endtask

  task automatic test_final_mark();
    // last mark on a dropped packet behind the window still counts
    send_header(make_hdr(exp_seq - 1, PACKET_BYTES, 1'b1));
    send_header(make_hdr(exp_seq + PACKET_BYTES, PACKET_BYTES, 1'b1));
    send_header(make_hdr(exp_seq, PACKET_BYTES, 1'b0));
  endtask

  task automatic test_random_traffic();
    for (int c = 0; c < RANDOM_CHUNKS; c++) begin
      idle_in = (c == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      idle_out = (c == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      for (int i = 0; i < CHUNK_WORDS; i++) send_header(random_header());
    end
  endtask

  task automatic test_backpressure();
    idle_in = 1'b0;
    idle_out = 1'b1;
    hold_request = 1'b1;
    for (int i = 0; i < PRESSURE_WORDS; i++) send_header(random_header());
  endtask

  // ack side: random readiness, one long hold when asked
  initial begin : ack_sink
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        out_ready = 1'b0;
        hold_request = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = idle_out ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // compare each ack word against the oldest prediction
  always @(posedge clk) begin : ack_check
    srrw_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_acks.size() == 0) begin
        $error("ack word %0d with nothing expected", out_data.ack_number);
        error_count++;
      end else begin
        want = pending_acks.pop_front();
        check_field("ack_number", want.ack_number, out_data.ack_number);
        check_field("action", want.action, out_data.action);
        check_field("slot_index", want.slot_index, out_data.slot_index);
        check_field("released_bytes", want.released_bytes, out_data.released_bytes);
        check_field("released_slots", want.released_slots, out_data.released_slots);
        check_field("transfer_done", want.transfer_done, out_data.transfer_done);
        ack_count++;
        if (out_data.action == ACT_DELIVER) deliver_count++;
        else if (out_data.action == ACT_STORE) store_count++;
        else drop_count++;
        if (out_data.transfer_done) done_count++;
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("stalled for %0d cycles with %0d acks owed", quiet_cycles, pending_acks.size());
      $display("selective_repeat_receive_window_core_test NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    idle_in = 1'b1;
    idle_out = 1'b1;
    hold_request = 1'b0;
    exp_seq = '0;
    last_seq = '1;
    for (int k = 0; k < WINDOW_SLOTS; k++) begin
      slot_full[k] = 1'b0;
      slot_len[k] = '0;
    end
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_in_order();
    test_window_fill();
    test_drops();
    test_final_mark();
    test_random_traffic();
    test_backpressure();

    // drain the remaining acks, then watch for strays
    in_valid = 1'b0;
    idle_out = 1'b0;
    while (pending_acks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d acks: %0d delivered, %0d buffered, %0d dropped, done on %0d",
             ack_count, deliver_count, store_count, drop_count, done_count);
    $display("window reached byte %0d, including a long output hold", exp_seq);
    if (error_count == 0) begin
      $display("selective_repeat_receive_window_core_test OK");
    end else begin
      $display("selective_repeat_receive_window_core_test NOT OK");
    end
    $finish;
  end

endmodule
